>>> rtl/tlop_pkg.sv
// Shared types, constants and the fixed-point helper for the occupancy pricer.
// No dependencies; used by the top level.
package tlop_pkg;

    localparam int COEF_W  = 31;   // probabilities and discount, 30 fractional bits
    localparam int HALF_W  = 24;   // operand half fed to the multiplier
    localparam int VFULL_W = 48;   // node value as seen by the multiplier
    localparam int PROD_W  = COEF_W + HALF_W;
    localparam int TERM_W  = 50;
    localparam int ACC_W   = 52;
    localparam int CIDX_W  = 3;
    localparam int CNT_W   = 7;
    localparam int BAR_IN_W = 9;
    localparam int PRICE_W = 31;
    localparam int FRAC_BITS = 30;

    localparam int DEF_MAX_STEPS  = 64;
    localparam int DEF_VALUE_BITS = 32;

    typedef enum logic [CIDX_W-1:0] {
        REG_PROB_UP   = 3'd0,
        REG_PROB_MID  = 3'd1,
        REG_PROB_DOWN = 3'd2,
        REG_DISCOUNT  = 3'd3,
        REG_STEPS     = 3'd4,
        REG_OCC_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_NODE_RD,
        S_NODE_LO,
        S_NODE_HI,
        S_NODE_ACC,
        S_FINAL_RD,
        S_FINAL_WAIT
    } state_t;

    typedef enum logic [1:0] {
        T_UP   = 2'd0,
        T_MID  = 2'd1,
        T_DOWN = 2'd2,
        T_DISC = 2'd3
    } term_t;

    // Recombines the two partial products of a 48-bit value times a coefficient
    // into floor(v * p / 2^30).
    function automatic logic [TERM_W-1:0] fx_term(input logic [PROD_W-1:0] hi,
                                                 input logic [PROD_W-1:0] lo);
        logic [PROD_W:0] low_sum;
        low_sum = {1'b0, lo} + ((PROD_W+1)'(hi[5:0]) << HALF_W);
        return TERM_W'(hi >> 6) + TERM_W'(low_sum >> FRAC_BITS);
    endfunction

endpackage

>>> rtl/tlop_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; instanced once per lattice plane.
module tlop_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/trinomial_lattice_occupancy_pricer.sv
// Top level of the trinomial lattice occupancy pricer: sequencer, datapath, two planes.
// Depends on tlop_pkg and tlop_ram.
//
// One request at a time: start is taken while busy is low, and the price word appears
// on done for a single cycle; the receiver cannot stall it. With m steps a request writes the
// (m+1)(2m+1) nodes of the terminal plane, then computes each of the
// sum over i < m of (i+1)(2i+1) interior nodes, then reads the root.
// Each node is read, then a 31 x 24 bit multiply forms two partial products (low half, then
// high half) for each of the three successor terms and the discount, each followed by an
// accumulate step. Nodes are read from one plane and written to the other; the read enable
// reaches both planes, but no read falls in the same cycle as a write.
module trinomial_lattice_occupancy_pricer #(
    parameter int MAX_STEPS  = tlop_pkg::DEF_MAX_STEPS,
    parameter int VALUE_BITS = tlop_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tlop_pkg::BAR_IN_W-1:0] barrier_index,
    output logic                                done,
    output logic [tlop_pkg::PRICE_W-1:0]        price,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlop_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [tlop_pkg::COEF_W-1:0]         cfg_data
);
    import tlop_pkg::*;

    localparam int ROW    = 2 * MAX_STEPS + 1;
    localparam int DEPTH  = (MAX_STEPS + 1) * ROW;
    localparam int AW     = $clog2(DEPTH);
    localparam int LW     = $clog2(MAX_STEPS + 1);
    localparam int JW     = LW + 1;
    localparam int CW     = ((JW > 10) ? JW : 10) + 2;
    localparam logic [ACC_W-1:0] VMAX = (ACC_W'(1) << VALUE_BITS) - ACC_W'(1);
    localparam logic [ACC_W-1:0] ONE_FX = ACC_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] ONE_SAT = (ONE_FX > VMAX) ? VMAX : ONE_FX;

    state_t state_reg, state_next;

    logic [COEF_W-1:0] prob_up_reg, prob_mid_reg, prob_down_reg, discount_reg;
    logic [CNT_W-1:0]  steps_reg, limit_reg;

    logic [LW-1:0]          m_reg, i_reg, k_reg;
    logic signed [JW-1:0]   j_reg;
    logic [AW-1:0]          base_reg;
    logic signed [CW-1:0]   bar_reg;
    logic                   sel_reg;
    term_t                  t_reg;
    logic [VFULL_W-1:0]     v_reg;
    logic [PROD_W-1:0]      prod_reg, lo_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [PRICE_W-1:0]     price_reg;
    logic                   done_reg;

    logic [VALUE_BITS-1:0]  rdata, rdata_a, rdata_b, wdata;
    logic [AW-1:0]          raddr, waddr;
    logic                   re, we, wsel;

    term_t                  rterm;
    logic signed [CW-1:0]   rj;
    logic                   bump;
    logic [COEF_W-1:0]      coef;
    logic [VFULL_W-1:0]     opnd;
    logic [TERM_W-1:0]      term;
    logic [ACC_W-1:0]       acc_sum, acc_sat, term_sat;
    logic [AW-1:0]          node_addr;
    logic                   last_j, last_k, fill_last_j, fill_last_k;
    logic signed [CW-1:0]   bar_in;
    logic [LW-1:0]          m_in;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign price     = price_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_up_reg   <= COEF_W'(268435456);
            prob_mid_reg  <= COEF_W'(536870912);
            prob_down_reg <= COEF_W'(268435456);
            discount_reg  <= COEF_W'(1073741824);
            steps_reg     <= CNT_W'(64);
            limit_reg     <= CNT_W'(52);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PROB_UP:   prob_up_reg   <= cfg_data;
                REG_PROB_MID:  prob_mid_reg  <= cfg_data;
                REG_PROB_DOWN: prob_down_reg <= cfg_data;
                REG_DISCOUNT:  discount_reg  <= cfg_data;
                REG_STEPS:     steps_reg     <= cfg_data[CNT_W-1:0];
                REG_OCC_LIMIT: limit_reg     <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Barrier saturation and step clamp at request time.
    always_comb
    begin
        bar_in = CW'(barrier_index);
        if (bar_in < -CW'(129))
        begin
            bar_in = -CW'(129);
        end
        else if (bar_in > CW'(128))
        begin
            bar_in = CW'(128);
        end
        if (steps_reg == '0)
        begin
            m_in = LW'(1);
        end
        else if (int'(steps_reg) > MAX_STEPS)
        begin
            m_in = LW'(MAX_STEPS);
        end
        else
        begin
            m_in = LW'(steps_reg);
        end
    end

    // Successor address: the occupancy row moves up by one when the successor is
    // at or below the barrier.
    always_comb
    begin
        rterm = (state_reg == S_NODE_ACC) ? term_t'(t_reg + 2'd1) : T_UP;
        unique case (rterm)
            T_UP:    rj = CW'(j_reg) + CW'(1);
            T_DOWN:  rj = CW'(j_reg) - CW'(1);
            default: rj = CW'(j_reg);
        endcase
        bump = (rj <= bar_reg);
        node_addr = base_reg + AW'(CW'(j_reg) + CW'(MAX_STEPS));
    end

    always_comb
    begin
        unique case (t_reg)
            T_UP:    coef = prob_up_reg;
            T_MID:   coef = prob_mid_reg;
            T_DOWN:  coef = prob_down_reg;
            default: coef = discount_reg;
        endcase
        acc_sat  = (acc_reg > VMAX) ? VMAX : acc_reg;
        opnd     = (t_reg == T_DISC) ? VFULL_W'(acc_sat) : VFULL_W'(rdata);
        term     = fx_term(prod_reg, lo_reg);
        acc_sum  = acc_reg + ACC_W'(term);
        term_sat = (ACC_W'(term) > VMAX) ? VMAX : ACC_W'(term);
        last_j      = (j_reg == JW'(i_reg));
        last_k      = (k_reg == i_reg);
        fill_last_j = (j_reg == JW'(m_reg));
        fill_last_k = (k_reg == m_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (start) state_next = S_FILL;
            S_FILL:       if (fill_last_j && fill_last_k) state_next = S_NODE_RD;
            S_NODE_RD:    state_next = S_NODE_LO;
            S_NODE_LO:    state_next = S_NODE_HI;
            S_NODE_HI:    state_next = S_NODE_ACC;
            S_NODE_ACC:
            begin
                if (t_reg != T_DISC)
                begin
                    state_next = S_NODE_LO;
                end
                else if (last_j && last_k && i_reg == '0)
                begin
                    state_next = S_FINAL_RD;
                end
                else
                begin
                    state_next = S_NODE_RD;
                end
            end
            S_FINAL_RD:   state_next = S_FINAL_WAIT;
            S_FINAL_WAIT: state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb
    begin
        re    = 1'b0;
        raddr = node_addr + (bump ? AW'(ROW) : '0) + AW'(rj - CW'(j_reg));
        we    = 1'b0;
        waddr = node_addr;
        wsel  = ~sel_reg;
        wdata = VALUE_BITS'(term_sat);
        unique case (state_reg)
            S_FILL:
            begin
                we    = 1'b1;
                wsel  = sel_reg;
                wdata = (int'(k_reg) < int'(limit_reg)) ? VALUE_BITS'(ONE_SAT) : '0;
            end
            S_NODE_RD:  re = 1'b1;
            S_NODE_ACC:
            begin
                re = (t_reg == T_UP) || (t_reg == T_MID);
                we = (t_reg == T_DISC);
            end
            S_FINAL_RD:
            begin
                re    = 1'b1;
                raddr = AW'(MAX_STEPS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINAL_WAIT);
            if (state_reg == S_NODE_ACC && t_reg == T_DISC && last_j && last_k)
            begin
                sel_reg <= ~sel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                bar_reg  <= bar_in;
                m_reg    <= m_in;
                k_reg    <= '0;
                j_reg    <= -JW'(m_in);
                base_reg <= '0;
            end
            S_FILL:
            begin
                if (fill_last_j)
                begin
                    if (fill_last_k)
                    begin
                        i_reg    <= m_reg - LW'(1);
                        k_reg    <= '0;
                        base_reg <= '0;
                        j_reg    <= -JW'(m_reg - LW'(1));
                    end
                    else
                    begin
                        k_reg    <= k_reg + LW'(1);
                        base_reg <= base_reg + AW'(ROW);
                        j_reg    <= -JW'(m_reg);
                    end
                end
                else
                begin
                    j_reg <= j_reg + JW'(1);
                end
            end
            S_NODE_RD:
            begin
                t_reg   <= T_UP;
                acc_reg <= '0;
            end
            S_NODE_LO:
            begin
                v_reg    <= opnd;
                prod_reg <= PROD_W'(coef) * PROD_W'(opnd[HALF_W-1:0]);
            end
            S_NODE_HI:
            begin
                lo_reg   <= prod_reg;
                prod_reg <= PROD_W'(coef) * PROD_W'(v_reg[VFULL_W-1:HALF_W]);
            end
            S_NODE_ACC:
            begin
                acc_reg <= acc_sum;
                t_reg   <= term_t'(t_reg + 2'd1);
                if (t_reg == T_DISC)
                begin
                    if (last_j)
                    begin
                        if (last_k)
                        begin
                            i_reg    <= i_reg - LW'(1);
                            k_reg    <= '0;
                            base_reg <= '0;
                            j_reg    <= -JW'(i_reg - LW'(1));
                        end
                        else
                        begin
                            k_reg    <= k_reg + LW'(1);
                            base_reg <= base_reg + AW'(ROW);
                            j_reg    <= -JW'(i_reg);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + JW'(1);
                    end
                end
            end
            S_FINAL_WAIT:
            begin
                price_reg <= (VFULL_W'(rdata) > VFULL_W'(ONE_FX)) ?
                             PRICE_W'(ONE_FX) : PRICE_W'(rdata);
            end
            default: ;
        endcase
    end

    tlop_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH), .ADDR_W(AW)) u_plane_a (
        .clk   (clk),
        .we    (we && !wsel),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    tlop_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH), .ADDR_W(AW)) u_plane_b (
        .clk   (clk),
        .we    (we && wsel),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    assign rdata = sel_reg ? rdata_b : rdata_a;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held for more than one cycle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted request did not raise busy");
    a_acc_after_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE_ACC) |-> ($past(state_reg) == S_NODE_HI))
        else $error("accumulate without both partial products");
    a_price_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (price <= PRICE_W'(ONE_FX))) else $error("price above one");
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (wsel != sel_reg)) else $error("read and write on one plane");
endmodule
